// ----- sv/mmse_pkg.sv -----
// Shared types, mode codes, character codes and encoding helpers for the string escaper.
package mmse_pkg;

  localparam int MODE_W = 4;
  localparam int MAX_CHARS = 6;
  localparam int LEN_W = 3;

  localparam logic [MODE_W-1:0] MODE_SQUOTE     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_DQUOTE     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_HTML       = 4'd2;
  localparam logic [MODE_W-1:0] MODE_LDAP_FLT   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LDAP_RDN   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_URL        = 4'd5;
  localparam logic [MODE_W-1:0] MODE_B64_STD    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_B64_URL    = 4'd7;
  localparam logic [MODE_W-1:0] MODE_B64_IMAP   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SQL_SQUOTE = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SQL_BQUOTE = 4'd10;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_BQUOTE  = 8'h60;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  // Entity texts, first character in the lowest slot.
  localparam logic [MAX_CHARS-1:0][7:0] ENT_QUOT =
      {8'h3B, 8'h74, 8'h6F, 8'h75, 8'h71, 8'h26};
  localparam logic [MAX_CHARS-1:0][7:0] ENT_AMP =
      {8'h00, 8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};
  localparam logic [MAX_CHARS-1:0][7:0] ENT_LT =
      {8'h00, 8'h00, 8'h3B, 8'h74, 8'h6C, 8'h26};
  localparam logic [MAX_CHARS-1:0][7:0] ENT_GT =
      {8'h00, 8'h00, 8'h3B, 8'h74, 8'h67, 8'h26};

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [LEN_W-1:0]          len;
    logic                      eos;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] w;
    w = {4'd0, n};
    return (n < 4'd10) ? 8'(8'd48 + w) : 8'(8'd55 + w);
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v, input logic [MODE_W-1:0] mode);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'd0, v};
    if (v < 6'd26) begin
      r = 8'(8'd65 + w);
    end else if (v < 6'd52) begin
      r = 8'(8'd71 + w);
    end else if (v < 6'd62) begin
      r = 8'(w - 8'd4);
    end else if (v == 6'd62) begin
      r = (mode == MODE_B64_URL) ? CH_MINUS : CH_PLUS;
    end else if (mode == MODE_B64_URL) begin
      r = CH_USCORE;
    end else begin
      r = (mode == MODE_B64_IMAP) ? CH_COMMA : CH_SLASH;
    end
    return r;
  endfunction

endpackage

// ----- sv/mmse_in_if.sv -----
// Input channel carrying one source string item.
interface mmse_in_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, has_char, char_in, end_of_string, input ready);
  modport sink (input valid, has_char, char_in, end_of_string, output ready);
endinterface

// ----- sv/mmse_out_if.sv -----
// Output channel carrying one encoded character item.
interface mmse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       run_last;
  logic       string_done;

  modport source (output valid, char_out, run_last, string_done, input ready);
  modport sink (input valid, char_out, run_last, string_done, output ready);
endinterface

// ----- sv/multi_mode_string_escaper.sv -----
// Top level of the multi-mode string escaper.
// Each accepted input item produces between zero and six output items, one character per
// cycle at the output port while it is ready: one or two for backslash and SQL quoting,
// up to six for an HTML entity, three for a hex escape, and four for a completed or flushed
// base64 group. The output port sets the rate; the input takes one item per cycle while
// the job queue (QUEUE_DEPTH entries) has room, and items that yield nothing are not
// queued. The mode register must only be written while the block is idle.
module multi_mode_string_escaper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mmse_pkg::MODE_W-1:0] cfg_wdata,
  mmse_in_if.sink                     in_chan,
  mmse_out_if.source                  out_chan
);

  logic [mmse_pkg::MODE_W-1:0] quote_mode;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_not_empty;
  mmse_pkg::job_t              q_in;
  mmse_pkg::job_t              q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= mmse_pkg::MODE_SQUOTE;
    end else if (cfg_we) begin
      quote_mode <= cfg_wdata;
    end
  end

  mmse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .mode    (quote_mode),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  mmse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  mmse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_chan    (out_chan)
  );

endmodule

// ----- sv/mmse_front.sv -----
// Front end: accepts string items, tracks base64 state and builds character jobs.
module mmse_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mmse_pkg::MODE_W-1:0] mode,
  mmse_in_if.sink                     in_chan,
  input  logic                        q_full,
  output logic                        q_push,
  output mmse_pkg::job_t              q_data
);

  logic [15:0] pending_bytes;
  logic [15:0] pending_bytes_next;
  logic [1:0]  pending_count;
  logic [1:0]  pending_count_next;

  logic        fire;
  logic        has;
  logic [7:0]  ch;
  logic [7:0]  hex_hi;
  logic [7:0]  hex_lo;
  logic        special;
  logic        group_done;
  logic [7:0]  b0;
  logic [7:0]  b1;
  mmse_pkg::job_t job;

  assign in_chan.ready = !q_full;
  assign fire = in_chan.valid && in_chan.ready;
  assign has = in_chan.has_char && (in_chan.char_in != 8'd0);
  assign ch = in_chan.char_in;
  assign hex_hi = mmse_pkg::hex_digit(ch[7:4]);
  assign hex_lo = mmse_pkg::hex_digit(ch[3:0]);

  always_comb begin
    special = 1'b0;
    if (mode == mmse_pkg::MODE_LDAP_FLT) begin
      case (ch) inside
        mmse_pkg::CH_LF, mmse_pkg::CH_STAR, mmse_pkg::CH_LPAREN, mmse_pkg::CH_RPAREN,
        mmse_pkg::CH_BSLASH: special = 1'b1;
        default: special = 1'b0;
      endcase
    end else if (mode == mmse_pkg::MODE_LDAP_RDN) begin
      case (ch) inside
        mmse_pkg::CH_LF, mmse_pkg::CH_SPACE, mmse_pkg::CH_DQUOTE, mmse_pkg::CH_HASH,
        mmse_pkg::CH_PLUS, mmse_pkg::CH_COMMA, mmse_pkg::CH_SEMI, mmse_pkg::CH_LT,
        mmse_pkg::CH_EQUAL, mmse_pkg::CH_GT, mmse_pkg::CH_BSLASH: special = 1'b1;
        default: special = 1'b0;
      endcase
    end else if (mode == mmse_pkg::MODE_URL) begin
      special = !((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                  (ch >= 8'h61 && ch <= 8'h7A) || ch == mmse_pkg::CH_MINUS ||
                  ch == mmse_pkg::CH_DOT || ch == mmse_pkg::CH_USCORE ||
                  ch == mmse_pkg::CH_TILDE);
    end
  end

  always_comb begin
    job = '0;
    job.eos = in_chan.end_of_string;
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    group_done = 1'b0;
    b0 = 8'd0;
    b1 = 8'd0;
    unique case (mode) inside
      mmse_pkg::MODE_SQUOTE, mmse_pkg::MODE_DQUOTE: begin
        if (has) begin
          if (ch == mmse_pkg::CH_BSLASH ||
              ch == ((mode == mmse_pkg::MODE_SQUOTE) ? mmse_pkg::CH_SQUOTE
                                                     : mmse_pkg::CH_DQUOTE)) begin
            job.chars[0] = mmse_pkg::CH_BSLASH;
            job.chars[1] = ch;
            job.len = 3'd2;
          end else begin
            job.chars[0] = ch;
            job.len = 3'd1;
          end
        end
      end
      mmse_pkg::MODE_HTML: begin
        if (has) begin
          case (ch)
            mmse_pkg::CH_DQUOTE: begin
              job.chars = mmse_pkg::ENT_QUOT;
              job.len = 3'd6;
            end
            mmse_pkg::CH_AMP: begin
              job.chars = mmse_pkg::ENT_AMP;
              job.len = 3'd5;
            end
            mmse_pkg::CH_LT: begin
              job.chars = mmse_pkg::ENT_LT;
              job.len = 3'd4;
            end
            mmse_pkg::CH_GT: begin
              job.chars = mmse_pkg::ENT_GT;
              job.len = 3'd4;
            end
            default: begin
              job.chars[0] = ch;
              job.len = 3'd1;
            end
          endcase
        end
      end
      mmse_pkg::MODE_LDAP_FLT, mmse_pkg::MODE_LDAP_RDN, mmse_pkg::MODE_URL: begin
        if (has) begin
          if (special) begin
            job.chars[0] = (mode == mmse_pkg::MODE_URL) ? mmse_pkg::CH_PERCENT
                                                        : mmse_pkg::CH_BSLASH;
            job.chars[1] = hex_hi;
            job.chars[2] = hex_lo;
            job.len = 3'd3;
          end else begin
            job.chars[0] = ch;
            job.len = 3'd1;
          end
        end
      end
      mmse_pkg::MODE_B64_STD, mmse_pkg::MODE_B64_URL, mmse_pkg::MODE_B64_IMAP: begin
        if (has) begin
          if (pending_count == 2'd2) begin
            group_done = 1'b1;
            b0 = pending_bytes[15:8];
            b1 = pending_bytes[7:0];
            job.chars[0] = mmse_pkg::b64_char(b0[7:2], mode);
            job.chars[1] = mmse_pkg::b64_char({b0[1:0], b1[7:4]}, mode);
            job.chars[2] = mmse_pkg::b64_char({b1[3:0], ch[7:6]}, mode);
            job.chars[3] = mmse_pkg::b64_char(ch[5:0], mode);
            job.len = 3'd4;
            pending_bytes_next = 16'd0;
            pending_count_next = 2'd0;
          end else begin
            pending_bytes_next = {pending_bytes[7:0], ch};
            pending_count_next = 2'(pending_count + 2'd1);
          end
        end
        if (in_chan.end_of_string && !group_done) begin
          if (pending_count_next == 2'd1) begin
            b0 = pending_bytes_next[7:0];
            job.chars[0] = mmse_pkg::b64_char(b0[7:2], mode);
            job.chars[1] = mmse_pkg::b64_char({b0[1:0], 4'd0}, mode);
            job.chars[2] = mmse_pkg::CH_EQUAL;
            job.chars[3] = mmse_pkg::CH_EQUAL;
            job.len = 3'd4;
          end else if (pending_count_next == 2'd2) begin
            b0 = pending_bytes_next[15:8];
            b1 = pending_bytes_next[7:0];
            job.chars[0] = mmse_pkg::b64_char(b0[7:2], mode);
            job.chars[1] = mmse_pkg::b64_char({b0[1:0], b1[7:4]}, mode);
            job.chars[2] = mmse_pkg::b64_char({b1[3:0], 2'd0}, mode);
            job.chars[3] = mmse_pkg::CH_EQUAL;
            job.len = 3'd4;
          end
        end
      end
      mmse_pkg::MODE_SQL_SQUOTE, mmse_pkg::MODE_SQL_BQUOTE: begin
        if (has) begin
          job.chars[0] = ch;
          if (ch == ((mode == mmse_pkg::MODE_SQL_SQUOTE) ? mmse_pkg::CH_SQUOTE
                                                         : mmse_pkg::CH_BQUOTE)) begin
            job.chars[1] = ch;
            job.len = 3'd2;
          end else begin
            job.len = 3'd1;
          end
        end
      end
      default: begin
        job.len = 3'd0;
      end
    endcase
    if (in_chan.end_of_string) begin
      pending_bytes_next = 16'd0;
      pending_count_next = 2'd0;
    end
  end

  assign q_push = fire && (job.len != 3'd0);
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= 16'd0;
      pending_count <= 2'd0;
    end else if (fire) begin
      pending_bytes <= pending_bytes_next;
      pending_count <= pending_count_next;
    end
  end

endmodule

// ----- sv/mmse_fifo.sv -----
// Short job queue between the front end and the character emitter.
module mmse_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmse_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mmse_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mmse_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

// ----- sv/mmse_back.sv -----
// Back end: emits the characters of each queued job, one per cycle while the output is ready.
module mmse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_not_empty,
  input  mmse_pkg::job_t q_data,
  output logic           q_pop,
  mmse_out_if.source     out_chan
);

  mmse_pkg::job_t             cur;
  logic [mmse_pkg::LEN_W-1:0] idx;
  logic                       busy;
  logic                       last;
  logic                       fire;

  assign last = (mmse_pkg::LEN_W'(idx + 1'b1) == cur.len);
  assign fire = out_chan.valid && out_chan.ready;
  assign q_pop = q_not_empty && (!busy || (fire && last));

  assign out_chan.valid = busy;
  assign out_chan.char_out = cur.chars[idx];
  assign out_chan.run_last = last;
  assign out_chan.string_done = last && cur.eos;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= mmse_pkg::LEN_W'(idx + 1'b1);
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cur.len))
    else $error("Character index ran past the job length.");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur.len != '0))
    else $error("An empty job reached the emitter.");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_chan.valid && out_chan.string_done) |-> out_chan.run_last)
    else $error("String end flagged on an item that is not the last of its run.");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (fire && !last) |=> (busy && idx == mmse_pkg::LEN_W'($past(idx) + 1'b1)))
    else $error("Emitter did not advance to the next character.");

endmodule
